// ===== rtl/well1024a_random_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the WELL1024a generator
// Shared concurrent assertion forms, clocked on clk with the active-low reset.
// ----------------------------------------------------------------------------
`ifndef WELL1024A_RANDOM_GENERATOR_MACROS_SVH
`define WELL1024A_RANDOM_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define W1024A_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define W1024A_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/w1024a_pkg.sv =====
// ----------------------------------------------------------------------------
// WELL1024a generator package
// Word and index types, operation codes and the state memory port bundles.
// ----------------------------------------------------------------------------
package w1024a_pkg;

  localparam int WORD_W  = 32;
  localparam int IDX_W   = 5;
  localparam int WORDS   = 32;
  localparam int SEED_W  = 64;
  localparam int FUNC_W  = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DRAW   = 2'd0,
    FUNC_SEED32 = 2'd1,
    FUNC_SEED64 = 2'd2
  } func_t;

  localparam word_t SEED_MULT = 32'd1812433253;

  // Tap offsets relative to the current index, modulo the state size.
  localparam idx_t OFF_VM1  = 5'd3;
  localparam idx_t OFF_VM2  = 5'd24;
  localparam idx_t OFF_VM3  = 5'd10;
  localparam idx_t OFF_ZP   = 5'd31;
  localparam idx_t IDX_LAST = idx_t'(WORDS - 1);

  typedef struct packed {
    logic  re;
    idx_t  addr_a;
    idx_t  addr_b;
  } ram_rd_t;

  typedef struct packed {
    logic  we;
    idx_t  addr;
    word_t data;
  } ram_wr_t;

endpackage

// ===== rtl/w1024a_state_ram.sv =====
// ----------------------------------------------------------------------------
// WELL1024a state memory
// 32 x 32 memory with two registered read ports and one write port. Per-entry
// valid flops make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`include "well1024a_random_generator_macros.svh"

module w1024a_state_ram (
  input  logic                clk,
  input  logic                rst_n,
  input  w1024a_pkg::ram_rd_t rd,
  input  w1024a_pkg::ram_wr_t wr,
  output w1024a_pkg::word_t   rd_data_a,
  output w1024a_pkg::word_t   rd_data_b
);
  import w1024a_pkg::*;

  word_t              mem [WORDS];
  logic [WORDS-1:0]   valid_r;
  word_t              data_a_r;
  word_t              data_b_r;
  logic               vld_a_r;
  logic               vld_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      data_a_r <= mem[rd.addr_a];
      data_b_r <= mem[rd.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.re) begin
        vld_a_r <= valid_r[rd.addr_a];
        vld_b_r <= valid_r[rd.addr_b];
      end
    end
  end

  assign rd_data_a = vld_a_r ? data_a_r : '0;
  assign rd_data_b = vld_b_r ? data_b_r : '0;

  `W1024A_ASSERT_NEXT(a_write_sets_valid, wr.we, valid_r[$past(wr.addr)], "written entry not valid")

endmodule

// ===== rtl/w1024a_seed_gen.sv =====
// ----------------------------------------------------------------------------
// WELL1024a seed expansion step
// Forms the next seeded word from the previous one and its position.
// ----------------------------------------------------------------------------
module w1024a_seed_gen (
  input  w1024a_pkg::word_t prev,
  input  w1024a_pkg::idx_t  pos,
  output w1024a_pkg::word_t next
);
  import w1024a_pkg::*;

  word_t mixed;
  word_t prod;

  assign mixed = prev ^ (prev >> 30);
  assign prod  = mixed * SEED_MULT;
  assign next  = prod + {{(WORD_W-IDX_W){1'b0}}, pos};

endmodule

// ===== rtl/well1024a_random_generator.sv =====
// ----------------------------------------------------------------------------
// WELL1024a random word generator
// Sequencer around a 32-word state memory: draws and seeding operations.
// ----------------------------------------------------------------------------
// Input items arrive on in_tvalid/in_tready; in_tuser selects the operation
// (draw, seed from 32 bits, seed from 64 bits, code 3 is a no-op) and
// in_tdata carries the seed. Draws return one word on out_tvalid/out_tready;
// seeds and no-ops return nothing.
// A draw fetches the five state words through the two read ports of the state
// memory, on acceptance and in steps D1 and D2, and writes the two updated
// words back through its single write port in steps D3 and D4, where the
// result is also loaded. No new item is accepted until the draw is done.
// A seed writes one state word per cycle, from word 0 up, set by the serial
// dependence of each word on the one before it.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls, the next draw holds in its last step until
// the register frees up.
// After reset the index is zero and every state word reads as zero; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`include "well1024a_random_generator_macros.svh"

module well1024a_random_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [w1024a_pkg::SEED_W-1:0]         in_tdata,  // seed_value
  input  logic [w1024a_pkg::FUNC_W-1:0]         in_tuser,  // func
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [w1024a_pkg::WORD_W-1:0]         out_tdata  // random_word
);
  import w1024a_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_D1,
    S_D2,
    S_D3,
    S_D4
  } state_t;

  state_t  state_r;
  idx_t    idx_r;
  idx_t    cnt_r;
  word_t   prev_r;
  word_t   key_lo_r;
  logic    two_key_r;
  word_t   z1_r;
  word_t   z2_r;
  word_t   w_r;
  logic    out_tvalid_r;
  word_t   out_tdata_r;

  ram_rd_t rd;
  ram_wr_t wr;
  word_t   rd_a;
  word_t   rd_b;
  word_t   seed_next;
  word_t   z1_nxt;
  word_t   z2_nxt;
  word_t   w_nxt;
  logic    accept;
  logic    stall;

  w1024a_state_ram u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd        (rd),
    .wr        (wr),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  w1024a_seed_gen u_seed (
    .prev (prev_r),
    .pos  (cnt_r),
    .next (seed_next)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign stall      = out_tvalid_r && !out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign z1_nxt = rd_a ^ rd_b ^ (rd_b >> 8);
  assign z2_nxt = rd_a ^ (rd_a << 19) ^ rd_b ^ (rd_b << 14);
  assign w_nxt  = rd_a ^ (rd_a << 11) ^ z1_r ^ (z1_r << 7) ^ z2_r ^ (z2_r << 13);

  always_comb begin
    rd = '0;
    wr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            FUNC_DRAW: begin
              rd.re     = 1'b1;
              rd.addr_a = idx_r;
              rd.addr_b = idx_r + OFF_VM1;
            end
            FUNC_SEED32: begin
              wr.we   = 1'b1;
              wr.data = in_tdata[WORD_W-1:0];
            end
            FUNC_SEED64: begin
              wr.we   = 1'b1;
              wr.data = in_tdata[SEED_W-1:WORD_W];
            end
            default: begin
            end
          endcase
        end
      end
      S_SEED: begin
        wr.we   = 1'b1;
        wr.addr = cnt_r;
        wr.data = (two_key_r && cnt_r == idx_t'(1)) ? key_lo_r : seed_next;
      end
      S_D1: begin
        rd.re     = 1'b1;
        rd.addr_a = idx_r + OFF_VM2;
        rd.addr_b = idx_r + OFF_VM3;
      end
      S_D2: begin
        rd.re     = 1'b1;
        rd.addr_a = idx_r + OFF_ZP;
        rd.addr_b = idx_r + OFF_ZP;
      end
      S_D3: begin
        wr.we   = 1'b1;
        wr.addr = idx_r;
        wr.data = z1_r ^ z2_r;
      end
      S_D4: begin
        wr.we   = !stall;
        wr.addr = idx_r + OFF_ZP;
        wr.data = w_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      cnt_r        <= '0;
      two_key_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // In the last draw step the output register is either held or reloaded.
      if (out_tready && state_r != S_D4) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_tuser)
              FUNC_DRAW: begin
                state_r <= S_D1;
              end
              FUNC_SEED32, FUNC_SEED64: begin
                state_r   <= S_SEED;
                cnt_r     <= idx_t'(1);
                prev_r    <= wr.data;
                key_lo_r  <= in_tdata[WORD_W-1:0];
                two_key_r <= (in_tuser == FUNC_SEED64);
              end
              default: begin
              end
            endcase
          end
        end
        S_SEED: begin
          prev_r <= wr.data;
          cnt_r  <= cnt_r + idx_t'(1);
          if (cnt_r == IDX_LAST) begin
            state_r <= S_IDLE;
            idx_r   <= '0;
          end
        end
        S_D1: begin
          z1_r    <= z1_nxt;
          state_r <= S_D2;
        end
        S_D2: begin
          z2_r    <= z2_nxt;
          state_r <= S_D3;
        end
        S_D3: begin
          w_r     <= w_nxt;
          state_r <= S_D4;
        end
        S_D4: begin
          if (!stall) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= w_r;
            idx_r        <= idx_r + OFF_ZP;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The memory reads before it writes, so a read and a write of one entry
  // in the same cycle would return a stale word.
  `W1024A_ASSERT_NOW(a_no_rw_overlap, wr.we && rd.re, wr.addr != rd.addr_a && wr.addr != rd.addr_b, "read and write hit the same entry")
  `W1024A_ASSERT_NEXT(a_seed_busy, accept && (in_tuser == FUNC_SEED32 || in_tuser == FUNC_SEED64), !in_tready, "seed did not start")
  `W1024A_ASSERT_NEXT(a_seed_index, state_r == S_SEED && cnt_r == IDX_LAST, idx_r == '0 && in_tready, "seed did not finish at index zero")
  `W1024A_ASSERT_NEXT(a_draw_step, state_r == S_D4 && !stall, out_tvalid && idx_r == $past(idx_r) + OFF_ZP, "draw did not step the index")

endmodule

// ===== tb/sv/well1024a_random_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the WELL1024a random word generator
// Drives draw, seed and unused-code items over the input stream and checks
// every returned word against a cycle-free model of the 32-word state, with
// random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module well1024a_random_generator_tb;
  import w1024a_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;
  localparam int CLK_HALF     = 4;
  localparam int ITEM_TARGET  = 1400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int REPORT_MAX   = 10;

  // Tap offsets of the recurrence, relative to the current index.
  localparam idx_t TAP_M1   = 5'd3;
  localparam idx_t TAP_M2   = 5'd24;
  localparam idx_t TAP_M3   = 5'd10;
  localparam idx_t TAP_PREV = 5'd31;
  localparam word_t INIT_MULT = 32'd1812433253;

  class well_scoreboard;
    word_t       words[WORDS];
    idx_t        pos;
    word_t       pending_words[$];
    int unsigned draws_seen;
    int unsigned seeds_seen;
    int unsigned ignored_seen;
    int unsigned words_checked;
    int unsigned errors;

    function new();
      foreach (words[i]) words[i] = '0;
      pos           = '0;
      draws_seen    = 0;
      seeds_seen    = 0;
      ignored_seen  = 0;
      words_checked = 0;
      errors        = 0;
    endfunction

    // Each word after the keys comes from the word before it.
    function void fill_words(int first);
      word_t prev;
      word_t mixed;
      for (int i = first; i < WORDS; i++) begin
        prev     = words[i-1];
        mixed    = prev ^ (prev >> 30);
        words[i] = mixed * INIT_MULT + word_t'(i);
      end
    endfunction

    function void note_item(logic [FUNC_W-1:0] f, logic [SEED_W-1:0] s);
      word_t v0, vm1, vm2, vm3, zp, z1, z2, tempered;
      idx_t  nxt;
      case (f)
        FUNC_DRAW: begin
          v0  = words[pos];
          vm1 = words[idx_t'(pos + TAP_M1)];
          vm2 = words[idx_t'(pos + TAP_M2)];
          vm3 = words[idx_t'(pos + TAP_M3)];
          nxt = idx_t'(pos + TAP_PREV);
          zp  = words[nxt];
          z1  = v0 ^ vm1 ^ (vm1 >> 8);
          z2  = vm2 ^ (vm2 << 19) ^ vm3 ^ (vm3 << 14);
          tempered = zp ^ (zp << 11) ^ z1 ^ (z1 << 7) ^ z2 ^ (z2 << 13);
          words[pos] = z1 ^ z2;
          words[nxt] = tempered;
          pos = nxt;
          pending_words.push_back(tempered);
          draws_seen++;
        end
        FUNC_SEED32: begin
          words[0] = s[31:0];
          fill_words(1);
          pos = '0;
          seeds_seen++;
        end
        FUNC_SEED64: begin
          words[0] = s[63:32];
          words[1] = s[31:0];
          fill_words(2);
          pos = '0;
          seeds_seen++;
        end
        default: begin
          ignored_seen++;
        end
      endcase
    endfunction

    function void check_word(word_t got);
      word_t want;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("ERROR: unexpected random_word %08h at %0t", got, $time);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("ERROR: random_word expected %08h, got %08h (word %0d)",
                     want, got, words_checked);
        end
      end
    endfunction
  endclass

  bit                  clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SEED_W-1:0]   in_tdata;   // seed_value
  logic [FUNC_W-1:0]   in_tuser;   // func
  logic                out_tvalid;
  logic                out_tready;
  logic [WORD_W-1:0]   out_tdata;  // random_word

  well_scoreboard sb;
  bit             calm;
  int unsigned    idle_cycles;

  well1024a_random_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [FUNC_W-1:0] f, input logic [SEED_W-1:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) begin
        in_tdata = {$urandom, $urandom};
        in_tuser = FUNC_W'($urandom);
        @(negedge clk);
      end
    end
    in_tvalid = 1'b1;
    in_tuser  = f;
    in_tdata  = s;
    do @(posedge clk); while (!in_tready);
    sb.note_item(f, s);
    @(negedge clk);
  endtask

  task automatic send_draws(input int count);
    repeat (count) send_item(FUNC_DRAW, {$urandom, $urandom});
  endtask

  // Receiver: mostly ready, with short stalls and now and then a long one; always ready while calm.
  initial begin
    int hold;
    int r;
    hold = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm) begin
        out_tready = 1'b1;
      end else if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_tready = 1'b1;
        end else if (r < 93) begin
          out_tready = 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_tready = 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
          $display("well1024a_random_generator verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int sent;
    int r;
    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = FUNC_DRAW;
    in_tdata    = '0;
    calm        = 1'b0;
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // A zeroed state draws zeros; the seed field is ignored on draws.
    send_item(FUNC_DRAW, '1);
    send_item(FUNC_DRAW, '0);
    send_item(FUNC_IGNORED, 64'hDEAD_BEEF_0123_4567);
    // A 32-bit seed uses only the low half.
    send_item(FUNC_SEED32, 64'hFFFF_FFFF_0000_0000);
    send_draws(2);
    send_item(FUNC_SEED32, 64'h0000_0000_FFFF_FFFF);
    send_draws(1);
    // The unused code must leave the state alone between draws.
    send_item(FUNC_IGNORED, '1);
    send_draws(1);
    send_item(FUNC_SEED64, '1);
    send_draws(2);
    send_item(FUNC_SEED64, '0);
    send_draws(1);
    send_item(FUNC_SEED64, 64'h8000_0000_0000_0001);
    send_draws(6);
    send_item(FUNC_SEED64, 64'h0123_4567_89AB_CDEF);
    send_draws(2);

    sent = 0;
    while (sent < ITEM_TARGET) begin
      calm = ((sent / 150) % 4) == 3;
      r = $urandom_range(0, 99);
      if (r < 82) begin
        send_item(FUNC_DRAW, {$urandom, $urandom});
        sent++;
      end else if (r < 90) begin
        send_item(FUNC_SEED32, {$urandom, $urandom});
        sent++;
      end else if (r < 97) begin
        send_item(FUNC_SEED64, {$urandom, $urandom});
        sent++;
      end else begin
        send_item(FUNC_IGNORED, {$urandom, $urandom});
      end
    end
    calm      = 1'b0;
    in_tvalid = 1'b0;

    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d draws, %0d seeds and %0d unused-code items;",
             sb.draws_seen, sb.seeds_seen, sb.ignored_seen);
    $display("%0d words checked, %0d errors, %0d words still owed.",
             sb.words_checked, sb.errors, sb.pending_words.size());
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("well1024a_random_generator verification clean");
    end else begin
      $display("well1024a_random_generator verification failed");
    end
    $finish;
  end

endmodule
